// ===== hdl/lzrd_pkg.sv =====
//------------------------------------------------------------------------------
// lzrd_pkg
// Shared types and constants for the LZ77 record decompressor.
//------------------------------------------------------------------------------
`default_nettype none

package lzrd_pkg;

   localparam int DATA_W  = 8;
   localparam int COUNT_W = 16;
   localparam int DIST_W  = 11;
   localparam int LEN_W   = 3;
   localparam int LEFT_W  = 4;
   localparam int HIGH_W  = 6;

   localparam int WINDOW_SIZE_DEFAULT = 2048;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MIN_MATCH           = 3;

   localparam logic [COUNT_W-1:0] MAX_OUTPUT_RESET = 16'd4096;

   localparam logic [DATA_W-1:0] LIT_RUN_MAX = 8'h08;
   localparam logic [DATA_W-1:0] LIT_LOW     = 8'h09;
   localparam logic [DATA_W-1:0] LIT_HIGH    = 8'h7F;
   localparam logic [DATA_W-1:0] PAIR_HIGH   = 8'hBF;
   localparam logic [DATA_W-1:0] SPACE_CHAR  = 8'h20;
   localparam logic [DATA_W-1:0] FLIP_MASK   = 8'h80;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_DIST = 2'd1,
      STATUS_TRUNC    = 2'd2,
      STATUS_LIMIT    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_LIT   = 2'd0,
      KIND_SPACE = 2'd1,
      KIND_COPY  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] data;
      logic [DIST_W-1:0] offset;
      logic [LEN_W-1:0]  len;
      logic              last;
      logic              trunc;
   } cmd_type;

endpackage

`default_nettype wire

// ===== hdl/lzrd_req_if.sv =====
//------------------------------------------------------------------------------
// lzrd_req_if
// Compressed byte channel.
//------------------------------------------------------------------------------
`default_nettype none

interface lzrd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lzrd_pkg::DATA_W-1:0]   in_byte;
   logic                          last_in;

   modport source (output valid, output in_byte, output last_in, input ready);
   modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

`default_nettype wire

// ===== hdl/lzrd_rsp_if.sv =====
//------------------------------------------------------------------------------
// lzrd_rsp_if
// Decompressed byte channel.
//------------------------------------------------------------------------------
`default_nettype none

interface lzrd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lzrd_pkg::DATA_W-1:0]   out_byte;
   logic                          byte_valid;
   lzrd_pkg::status_type          status;
   logic                          end_of_run;
   logic                          end_of_record;
   logic [lzrd_pkg::COUNT_W-1:0]  out_count;

   modport source (output valid, output out_byte, output byte_valid, output status,
                   output end_of_run, output end_of_record, output out_count,
                   input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input status,
                   input end_of_run, input end_of_record, input out_count,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/lzrd_front.sv =====
//------------------------------------------------------------------------------
// lzrd_front
// Parses compressed bytes into commands for the back end.
//------------------------------------------------------------------------------
`default_nettype none

module lzrd_front (
   input  wire logic          clock,
   input  wire logic          reset,
   lzrd_req_if.sink           req,
   input  wire logic          q_full,
   output logic               push_valid,
   output lzrd_pkg::cmd_type  push_cmd
);

   typedef enum logic [2:0] {
      PH_CMD  = 3'b001,
      PH_LIT  = 3'b010,
      PH_PAIR = 3'b100
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [lzrd_pkg::LEFT_W-1:0]    left_ff, left_in, left_dec;
   logic [lzrd_pkg::HIGH_W-1:0]    high_ff, high_in;
   logic                           accept;
   logic [lzrd_pkg::DATA_W-1:0]    ch;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign ch        = req.in_byte;
   assign left_dec  = left_ff - lzrd_pkg::LEFT_W'(1);

   always_comb begin
      phase_in        = phase_ff;
      left_in         = left_ff;
      high_in         = high_ff;
      push_cmd.kind   = lzrd_pkg::KIND_NONE;
      push_cmd.data   = ch;
      push_cmd.offset = {high_ff, ch[7:3]};
      push_cmd.len    = ch[2:0];
      push_cmd.last   = req.last_in;
      push_cmd.trunc  = 1'b0;
      unique case (phase_ff)
         PH_LIT: begin
            push_cmd.kind  = lzrd_pkg::KIND_LIT;
            left_in        = left_dec;
            phase_in       = (left_dec == '0) ? PH_CMD : PH_LIT;
            push_cmd.trunc = req.last_in && (left_dec != '0);
         end
         PH_PAIR: begin
            push_cmd.kind = lzrd_pkg::KIND_COPY;
            phase_in      = PH_CMD;
         end
         PH_CMD: begin
            priority if (ch == '0 || (ch >= lzrd_pkg::LIT_LOW && ch <= lzrd_pkg::LIT_HIGH)) begin
               push_cmd.kind = lzrd_pkg::KIND_LIT;
            end else if (ch <= lzrd_pkg::LIT_RUN_MAX) begin
               left_in        = ch[lzrd_pkg::LEFT_W-1:0];
               phase_in       = PH_LIT;
               push_cmd.trunc = req.last_in;
            end else if (ch <= lzrd_pkg::PAIR_HIGH) begin
               high_in        = ch[lzrd_pkg::HIGH_W-1:0];
               phase_in       = PH_PAIR;
               push_cmd.trunc = req.last_in;
            end else begin
               push_cmd.kind = lzrd_pkg::KIND_SPACE;
            end
         end
         default: begin
            phase_in = PH_CMD;
         end
      endcase
      if (req.last_in) begin
         phase_in = PH_CMD;
         left_in  = '0;
         high_in  = '0;
      end
   end

   assign push_valid = accept && (push_cmd.kind != lzrd_pkg::KIND_NONE || req.last_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
         left_ff  <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         high_ff  <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lzrd_queue.sv =====
//------------------------------------------------------------------------------
// lzrd_queue
// Small command FIFO between parser and executor.
//------------------------------------------------------------------------------
`default_nettype none

module lzrd_queue #(
   parameter int DEPTH = lzrd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  lzrd_pkg::cmd_type  push_cmd,
   output logic               full,
   input  wire logic          pop,
   output logic               head_valid,
   output lzrd_pkg::cmd_type  head_cmd
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lzrd_pkg::cmd_type  entry_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lzrd_back.sv =====
//------------------------------------------------------------------------------
// lzrd_back
// Executes commands: literals, space pairs and history copies.
//------------------------------------------------------------------------------
`default_nettype none

module lzrd_back #(
   parameter int WINDOW_SIZE = lzrd_pkg::WINDOW_SIZE_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  lzrd_pkg::cmd_type                  head_cmd,
   output logic                               pop,
   input  wire logic [lzrd_pkg::COUNT_W-1:0]  max_output,
   lzrd_rsp_if.source                         rsp
);

   localparam int AW = $clog2(WINDOW_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SECOND = 4'b0010,
      ST_COPY   = 4'b0100,
      ST_TRUNC  = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   lzrd_pkg::cmd_type               cmd_ff, cmd_in, cur;
   logic [lzrd_pkg::LEFT_W-1:0]     left_ff, left_in;
   logic [AW-1:0]                   wp_ff, wp_in, wp_next, rd_addr;
   logic [lzrd_pkg::COUNT_W-1:0]    pc_ff, pc_in, e_count;

   logic [lzrd_pkg::DATA_W-1:0]     hist [WINDOW_SIZE];
   logic [lzrd_pkg::DATA_W-1:0]     rd_q_ff, fwd_data_ff, copy_data;
   logic                            fwd_hit_ff;
   logic                            rd_en, we;

   logic                            out_free, prod_req, prod_ok, emit, e_valid, e_final;
   logic                            bad_dist;
   logic [lzrd_pkg::DATA_W-1:0]     prod_byte, e_byte;
   lzrd_pkg::status_type            e_status;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lzrd_pkg::DATA_W-1:0]     out_byte_ff;
   logic                            byte_valid_ff, eor_run_ff, eor_rec_ff;
   lzrd_pkg::status_type            status_ff;
   logic [lzrd_pkg::COUNT_W-1:0]    out_count_ff;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign prod_ok   = pc_ff < max_output;
   assign copy_data = fwd_hit_ff ? fwd_data_ff : rd_q_ff;
   assign bad_dist  = (head_cmd.offset == '0) ||
                      (lzrd_pkg::COUNT_W'(head_cmd.offset) > pc_ff);
   assign wp_next   = prod_ok ? wp_ff + AW'(1) : wp_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      left_in   = left_ff;
      cur       = cmd_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      e_status  = lzrd_pkg::STATUS_OK;
      e_final   = 1'b0;
      prod_req  = 1'b0;
      prod_byte = '0;
      rd_en     = 1'b0;
      rd_addr   = wp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cur = head_cmd;
            if (head_valid && out_free) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               unique case (head_cmd.kind)
                  lzrd_pkg::KIND_LIT: begin
                     prod_req  = 1'b1;
                     prod_byte = head_cmd.data;
                     if (head_cmd.trunc) state_in = ST_TRUNC;
                     else e_final = 1'b1;
                  end
                  lzrd_pkg::KIND_SPACE: begin
                     prod_req  = 1'b1;
                     prod_byte = lzrd_pkg::SPACE_CHAR;
                     state_in  = ST_SECOND;
                  end
                  lzrd_pkg::KIND_COPY: begin
                     if (bad_dist) begin
                        emit     = 1'b1;
                        e_status = lzrd_pkg::STATUS_BAD_DIST;
                        if (head_cmd.trunc) state_in = ST_TRUNC;
                        else e_final = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = wp_ff - AW'(head_cmd.offset);
                        left_in  = {1'b0, head_cmd.len} + lzrd_pkg::LEFT_W'(lzrd_pkg::MIN_MATCH);
                        state_in = ST_COPY;
                     end
                  end
                  default: begin
                     emit     = 1'b1;
                     e_status = lzrd_pkg::STATUS_TRUNC;
                     e_final  = 1'b1;
                  end
               endcase
            end
         end
         ST_SECOND: begin
            if (out_free) begin
               prod_req  = 1'b1;
               prod_byte = cmd_ff.data ^ lzrd_pkg::FLIP_MASK;
               state_in  = cmd_ff.trunc ? ST_TRUNC : ST_IDLE;
               e_final   = !cmd_ff.trunc;
            end
         end
         ST_COPY: begin
            if (out_free) begin
               prod_req  = 1'b1;
               prod_byte = copy_data;
               left_in   = left_ff - lzrd_pkg::LEFT_W'(1);
               if (left_ff == lzrd_pkg::LEFT_W'(1)) begin
                  state_in = cmd_ff.trunc ? ST_TRUNC : ST_IDLE;
                  e_final  = !cmd_ff.trunc;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = wp_next - AW'(cmd_ff.offset);
               end
            end
         end
         ST_TRUNC: begin
            if (out_free) begin
               emit     = 1'b1;
               e_status = lzrd_pkg::STATUS_TRUNC;
               e_final  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (prod_req && !prod_ok) begin
         e_status = lzrd_pkg::STATUS_LIMIT;
      end
   end

   always_comb begin
      we      = prod_req && prod_ok;
      e_valid = we;
      e_byte  = we ? prod_byte : '0;
      e_count = we ? pc_ff + lzrd_pkg::COUNT_W'(1) : pc_ff;
      wp_in   = we ? wp_ff + AW'(1) : wp_ff;
      pc_in   = e_count;
      if ((emit || prod_req) && e_final && cur.last) begin
         wp_in = '0;
         pc_in = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (emit || prod_req) begin
         rsp_valid_in = 1'b1;
      end
   end

   // history ring; a read of the slot written in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (we) begin
         hist[wp_ff] <= prod_byte;
      end
      if (rd_en) begin
         rd_q_ff     <= hist[rd_addr];
         fwd_hit_ff  <= we && (rd_addr == wp_ff);
         fwd_data_ff <= prod_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (emit || prod_req) begin
         out_byte_ff   <= e_byte;
         byte_valid_ff <= e_valid;
         status_ff     <= e_status;
         eor_run_ff    <= e_final;
         eor_rec_ff    <= e_final && cur.last;
         out_count_ff  <= e_count;
      end
      cmd_ff  <= cmd_in;
      left_ff <= left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.out_byte      = out_byte_ff;
   assign rsp.byte_valid    = byte_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.end_of_run    = eor_run_ff;
   assign rsp.end_of_record = eor_rec_ff;
   assign rsp.out_count     = out_count_ff;

endmodule

`default_nettype wire

// ===== hdl/lz77_record_decompressor_core.sv =====
//------------------------------------------------------------------------------
// lz77_record_decompressor_core
// Record decompressor: parser front end, command queue, executor with a
// history ring.
//
//   Channel | Direction | Carries
//   --------+-----------+-------------------------------------------------
//   req_if  | in        | in_byte, last_in
//   rsp_if  | out       | out_byte, byte_valid, status, end_of_run,
//           |           | end_of_record, out_count
//   csr_*   | in        | max_output write (csr_we, csr_wdata)
//
// The parser takes a byte into the command queue whenever the queue is not
// full; the executor gives one result per cycle while a command is queued
// and the output register is free, and none during a copy's first history read.
// Synchronous reset; the history ring is not cleared.
// Input stalls only when the command queue is full; output stalls hold the
// executor through the output register.
//------------------------------------------------------------------------------
`default_nettype none

module lz77_record_decompressor_core #(
   parameter int WINDOW_SIZE = lzrd_pkg::WINDOW_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = lzrd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lzrd_req_if.sink                           req_if,
   lzrd_rsp_if.source                         rsp_if,
   input  wire logic                          csr_we,
   input  wire logic [lzrd_pkg::COUNT_W-1:0]  csr_wdata
);

   logic [lzrd_pkg::COUNT_W-1:0]  max_output_ff;
   logic                          push_valid, q_full, pop, head_valid;
   lzrd_pkg::cmd_type             push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_output_ff <= lzrd_pkg::MAX_OUTPUT_RESET;
      end else if (csr_we) begin
         max_output_ff <= csr_wdata;
      end
   end

   lzrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   lzrd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   lzrd_back #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .max_output (max_output_ff),
      .rsp        (rsp_if)
   );

   a_byte_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.byte_valid |-> rsp_if.status == lzrd_pkg::STATUS_OK)
      else $error("produced byte carries an error status");

   a_nobyte_err : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.byte_valid |-> rsp_if.status != lzrd_pkg::STATUS_OK)
      else $error("empty item without error status");

   a_record_run : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.end_of_record |-> rsp_if.end_of_run)
      else $error("end of record without end of run");

   a_count_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.byte_valid |->
         rsp_if.out_count != '0 && rsp_if.out_count <= max_output_ff)
      else $error("byte count outside the output limit");

endmodule

`default_nettype wire
